// ===== hw/rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared types and constants for the modular exponentiation block: the
// controller state encoding and the register map of the configuration port.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;

    // Register index taken from the word address bit of paddr.
    localparam logic REG_MODULUS = 1'b0;

    localparam logic [31:0] MODULUS_RESET_VALUE = 32'd1000000007;

    localparam int CMD_WIDTH = 1;
    localparam logic CMD_POWER   = 1'b0;
    localparam logic CMD_INVERSE = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_REDUCE = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_SQR    = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

endpackage

// ===== hw/rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation
// A request is worked through with the bit-serial multiplier; a zero effective
// exponent or a zero modulus skips it. One request is processed at a time; the
// next is taken once the result is registered. Reset sets the modulus to
// 1000000007 and empties the block.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int DATA_WIDTH = 31,
    parameter int EXP_WIDTH  = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mexp_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [mexp_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [mexp_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [mexp_pkg::CMD_WIDTH-1:0]        cmd,
    input  logic [DATA_WIDTH-1:0]                 base,
    input  logic [EXP_WIDTH-1:0]                  exponent,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [DATA_WIDTH-1:0]                 result
);

    import mexp_pkg::*;

    localparam int XW = (EXP_WIDTH > DATA_WIDTH) ? EXP_WIDTH : DATA_WIDTH;
    localparam logic [DATA_WIDTH-1:0] MODULUS_RESET = DATA_WIDTH'(MODULUS_RESET_VALUE);

    state_t                state_reg, state_next;
    logic                  launch_reg, launch_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] modulus_reg, modulus_next;
    logic [XW-1:0]         e_reg, e_next;
    logic [DATA_WIDTH-1:0] pow_reg, pow_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic [DATA_WIDTH-1:0] result_reg, result_next;

    logic                  accept;
    logic                  cfg_write;
    logic [XW-1:0]         eff_exp;
    logic [DATA_WIDTH-1:0] mul_b;
    logic                  mul_done;
    logic [DATA_WIDTH-1:0] mul_product;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MODULUS);
    assign prdata    = (paddr[2] == REG_MODULUS) ?
                       APB_DATA_WIDTH'(modulus_reg) : '0;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        if (cmd == CMD_INVERSE)
        begin
            if (modulus_reg < DATA_WIDTH'(3))
            begin
                eff_exp = '0;
            end
            else
            begin
                eff_exp = XW'(modulus_reg) - XW'(2);
            end
        end
        else
        begin
            eff_exp = XW'(exponent);
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_REDUCE: mul_b = DATA_WIDTH'(1);
            ST_MUL:    mul_b = acc_reg;
            default:   mul_b = pow_reg;
        endcase
    end

    mexp_mulmod #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (launch_reg),
        .a       (pow_reg),
        .b       (mul_b),
        .m       (modulus_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    always_comb
    begin
        state_next     = state_reg;
        launch_next    = 1'b0;
        modulus_next   = cfg_write ? pwdata[DATA_WIDTH-1:0] : modulus_reg;
        e_next         = e_reg;
        pow_next       = pow_reg;
        acc_next       = acc_reg;
        result_next    = result_reg;
        out_valid_next = (out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    e_next   = eff_exp;
                    pow_next = base;
                    if (eff_exp == '0)
                    begin
                        acc_next   = DATA_WIDTH'(1);
                        state_next = ST_FINISH;
                    end
                    else if (modulus_reg == '0)
                    begin
                        acc_next   = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        acc_next    = DATA_WIDTH'(1);
                        launch_next = 1'b1;
                        state_next  = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (mul_done)
                begin
                    pow_next   = mul_product;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (e_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (e_reg[0])
                begin
                    launch_next = 1'b1;
                    state_next  = ST_MUL;
                end
                else
                begin
                    launch_next = 1'b1;
                    state_next  = ST_SQR;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    acc_next    = mul_product;
                    launch_next = 1'b1;
                    state_next  = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (mul_done)
                begin
                    pow_next   = mul_product;
                    e_next     = {1'b0, e_reg[XW-1:1]};
                    state_next = ST_SCAN;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    result_next    = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            modulus_reg   <= MODULUS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
            modulus_reg   <= modulus_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg      <= e_next;
        pow_reg    <= pow_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

endmodule

// ===== hw/rtl/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Interleaved shift-and-add multiplication: one bit of the first operand per
// cycle, most significant first, with the partial sum kept below the modulus.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
    parameter int DATA_WIDTH = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] a,
    input  logic [DATA_WIDTH-1:0] b,
    input  logic [DATA_WIDTH-1:0] m,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] product
);

    localparam int CW = $clog2(DATA_WIDTH + 1);
    localparam int TW = DATA_WIDTH + 2;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic [DATA_WIDTH-1:0] r_reg, r_next;

    logic [TW-1:0] t;
    logic [TW:0]   d1;
    logic [TW:0]   d2;
    logic [TW-1:0] sel;

    // The partial sum stays below 3m, so at most two subtractions are needed.
    always_comb
    begin
        t   = {1'b0, r_reg, 1'b0} + (a_reg[DATA_WIDTH-1] ? {2'b00, b_reg} : {TW{1'b0}});
        d1  = {1'b0, t} - {3'b000, m};
        d2  = {1'b0, t} - {2'b00, m, 1'b0};
        if (!d2[TW])
        begin
            sel = d2[TW-1:0];
        end
        else if (!d1[TW])
        begin
            sel = d1[TW-1:0];
        end
        else
        begin
            sel = t;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DATA_WIDTH);
            a_next    = a;
            b_next    = b;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next   = sel[DATA_WIDTH-1:0];
            a_next   = {a_reg[DATA_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign done    = done_reg;
    assign product = r_reg;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives power and inverse requests through the block under several modulus
// settings written over the configuration port. A scoreboard predicts each
// result with square and multiply arithmetic and checks results in order.
// Both handshake sides idle at random, and the result side holds off once
// long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_WIDTH     = 31;
    localparam int EXP_WIDTH      = 32;
    localparam int CLK_PERIOD     = 10;
    localparam int RANDOM_ITEMS   = 28;
    localparam int HOLD_CYCLES    = 3000;
    localparam int TAIL_CYCLES    = 2200;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [DATA_WIDTH-1:0] BASE_MAX = '1;
    localparam logic [EXP_WIDTH-1:0]  EXP_MAX  = '1;
    localparam logic [mexp_pkg::APB_ADDR_WIDTH-1:0] MODULUS_ADDR =
        {mexp_pkg::REG_MODULUS, 2'b00};
    localparam int unsigned MODULI [8] =
        '{32'd2147483647, 32'd1, 32'd2, 32'd3, 32'd4, 32'd97, 32'd65536, 32'd1000000007};

    typedef logic [mexp_pkg::CMD_WIDTH-1:0] cmd_t;
    typedef logic [DATA_WIDTH-1:0]          word_t;
    typedef logic [EXP_WIDTH-1:0]           exp_t;

    class modexp_tracker;
        word_t modulus;
        word_t pending_results [$];
        int    mismatches;

        function new();
            modulus    = DATA_WIDTH'(mexp_pkg::MODULUS_RESET_VALUE);
            mismatches = 0;
        endfunction

        function word_t predict_power(cmd_t c, word_t b, exp_t e);
            longint unsigned m;
            longint unsigned ex;
            longint unsigned acc;
            longint unsigned sq;
            m = 64'(modulus);
            if (c == mexp_pkg::CMD_INVERSE)
            begin
                if (m < 3)
                    return DATA_WIDTH'(1);
                ex = m - 2;
            end
            else
                ex = 64'(e);
            if (ex == 0)
                return DATA_WIDTH'(1);
            if (m == 0)
                return '0;
            acc = 1;
            sq  = 64'(b);
            while (ex != 0)
            begin
                if (ex[0])
                    acc = (acc * sq) % m;
                sq = (sq * sq) % m;
                ex = ex >> 1;
            end
            return DATA_WIDTH'(acc);
        endfunction

        function void note_request(cmd_t c, word_t b, exp_t e);
            pending_results = {pending_results, predict_power(c, b, e)};
        endfunction

        function void check_result(word_t r);
            word_t want;
            if (pending_results.size() == 0)
            begin
                $error("result: expected none, actual %0d", r);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (r !== want)
            begin
                $error("result: expected %0d, actual %0d", want, r);
                mismatches++;
            end
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [mexp_pkg::APB_ADDR_WIDTH-1:0] paddr;
    logic [mexp_pkg::APB_DATA_WIDTH-1:0] pwdata;
    logic [mexp_pkg::APB_DATA_WIDTH-1:0] prdata;
    logic                                pready;
    logic                                in_valid;
    logic                                in_stall;
    cmd_t                                cmd;
    word_t                               base;
    exp_t                                exponent;
    logic                                out_valid;
    logic                                out_stall;
    word_t                               result;

    modexp_tracker sb = new();
    int            idle_cycles;
    int            results_taken;

    modular_exponentiation #(
        .DATA_WIDTH (DATA_WIDTH),
        .EXP_WIDTH  (EXP_WIDTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .base      (base),
        .exponent  (exponent),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    initial
        clk = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(cmd, base, exponent);
            if (out_valid && !out_stall)
            begin
                sb.check_result(result);
                results_taken <= results_taken + 1;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        idle_cycles   = 0;
        results_taken = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int  style;
        int  style_cycles;
        bit  held;
        out_stall    = 1'b0;
        style        = 0;
        style_cycles = 0;
        held         = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && results_taken >= 12)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (style_cycles == 0)
                begin
                    style        = $urandom_range(0, 3);
                    style_cycles = $urandom_range(16, 256);
                end
                style_cycles--;
                case (style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 2) == 0);
                    2:       out_stall <= ~out_stall;
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic apb_write(logic [mexp_pkg::APB_ADDR_WIDTH-1:0] addr,
                             logic [mexp_pkg::APB_DATA_WIDTH-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(logic [mexp_pkg::APB_ADDR_WIDTH-1:0] addr,
                             logic [mexp_pkg::APB_DATA_WIDTH-1:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            $error("modulus: expected %0d, actual %0d", want, prdata);
            sb.mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic offer(cmd_t c, word_t b, exp_t e);
        @(negedge clk);
        in_valid <= 1'b1;
        cmd      <= c;
        base     <= b;
        exponent <= e;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic idle_gap(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic make_request(output cmd_t c, output word_t b, output exp_t e);
        longint unsigned m;
        longint unsigned k;
        m = (sb.modulus == 0) ? 1 : sb.modulus;
        c = ($urandom_range(0, 3) == 0) ? mexp_pkg::CMD_INVERSE : mexp_pkg::CMD_POWER;
        case ($urandom_range(0, 7))
            0: b = '0;
            1: b = BASE_MAX;
            2:
            begin
                k = $urandom_range(1, 32'(longint'(BASE_MAX) / m));
                b = DATA_WIDTH'(m * k);
            end
            3: b = $urandom_range(0, 1) ? DATA_WIDTH'(1) : DATA_WIDTH'(m - 1);
            default: b = DATA_WIDTH'($urandom());
        endcase
        case ($urandom_range(0, 7)) inside
            0:       e = '0;
            1:       e = EXP_MAX;
            [2:3]:   e = $urandom_range(1, 255);
            default: e = $urandom();
        endcase
    endtask

    task automatic send_random(int count);
        int    burst;
        cmd_t  c;
        word_t b;
        exp_t  e;
        burst = 0;
        repeat (count)
        begin
            if (burst == 0)
            begin
                idle_gap($urandom_range(0, 6));
                burst = $urandom_range(1, 8);
            end
            make_request(c, b, e);
            offer(c, b, e);
            burst--;
        end
        idle_gap(1);
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int unsigned m;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        cmd      = mexp_pkg::CMD_POWER;
        base     = '0;
        exponent = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        apb_check(MODULUS_ADDR, mexp_pkg::MODULUS_RESET_VALUE);
        offer(mexp_pkg::CMD_POWER,   '0,                   '0);
        offer(mexp_pkg::CMD_POWER,   '0,                   32'd5);
        offer(mexp_pkg::CMD_POWER,   BASE_MAX,             '0);
        offer(mexp_pkg::CMD_POWER,   BASE_MAX,             EXP_MAX);
        offer(mexp_pkg::CMD_POWER,   31'd1,                EXP_MAX);
        offer(mexp_pkg::CMD_POWER,   31'd2,                32'd1);
        offer(mexp_pkg::CMD_POWER,   31'd1000000007,       32'd3);
        offer(mexp_pkg::CMD_POWER,   31'd2000000014,       32'd1);
        offer(mexp_pkg::CMD_POWER,   31'd5,                32'h8000_0000);
        offer(mexp_pkg::CMD_INVERSE, '0,                   32'd77);
        offer(mexp_pkg::CMD_INVERSE, 31'd1,                '0);
        offer(mexp_pkg::CMD_INVERSE, 31'd2,                EXP_MAX);
        offer(mexp_pkg::CMD_INVERSE, BASE_MAX,             32'd123);
        offer(mexp_pkg::CMD_INVERSE, 31'd1000000008,       '0);
        idle_gap(1);
        send_random(RANDOM_ITEMS);

        for (int i = 0; i <= $size(MODULI); i++)
        begin
            wait_drained();
            m = (i == $size(MODULI)) ? $urandom_range(32'h7FFF_FFFF, 3) : MODULI[i];
            apb_write(MODULUS_ADDR, m);
            apb_check(MODULUS_ADDR, m);
            sb.modulus = DATA_WIDTH'(m);
            send_random(RANDOM_ITEMS);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_mulmod.sv
hw/rtl/modular_exponentiation.sv
tb/tb.sv
